// ----- sv/frst_pkg.sv -----
// shared types and constants for the fenwick range sum table
package frst_pkg;

  localparam int POS_W             = 11;
  localparam int DATA_W            = 32;
  localparam int OP_W              = 2;
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int SIZE_RESET        = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QUERY,
    ST_CLEAR
  } state_t;

endpackage

// ----- sv/fenwick_range_sum_table.sv -----
// fenwick range sum table: binary indexed tree over one synchronous memory
//
// Takes one item at a time: an item is accepted on a clock edge with start high
// and busy low, and its single result shows on out_* for exactly one cycle with
// out_valid high; the receiver cannot stall it. An add walks the update chain
// p += p & -p with a read step and a write step per cell (ST_ADD_RD, then
// ST_ADD_WR) until p passes size_in_use. A range query walks the two prefix
// chains p -= p & -p with one memory read per cycle, the right chain first and
// the left chain after a turnaround step, and subtracts the left prefix from
// the right. The single read port of the cell memory paces both walks. A clear
// writes zero to one cell per cycle across all MAX_POSITIONS cells; the same
// clearing pass runs after reset, with busy high until it ends, before the
// first item can be taken. A bad position or an unknown opcode answers with
// status 1 in the cycle after acceptance. The size register is written through
// cfg_valid (cfg_ready is always high); the user must write it only while the
// block is idle, which the block itself does not enforce.
module fenwick_range_sum_table
  import frst_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // item input
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic [POS_W-1:0]         in_first_position,
  input  logic [POS_W-1:0]         in_second_position,
  input  logic signed [DATA_W-1:0] in_delta,
  // result output
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_range_total,
  output logic                     out_status,
  // size register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [POS_W-1:0]         cfg_size_in_use
);

  // cell p of the tree lives at address p - 1
  localparam int ADDR_W   = (MAX_POSITIONS > 2) ? $clog2(MAX_POSITIONS) : 1;
  // walk pointer holds p + lowbit(p) for any p up to the widest position
  localparam int PTR_W    = POS_W + 1;
  localparam int SIZE_RST = (MAX_POSITIONS < SIZE_RESET) ? MAX_POSITIONS : SIZE_RESET;

  // cell memory, one read and one write port, registered read data
  logic [DATA_W-1:0] mem [MAX_POSITIONS];
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rdata_r;

  // control state
  state_t            state_r,     state_nxt;
  logic [ADDR_W-1:0] clr_idx_r,   clr_idx_nxt;
  logic              clr_resp_r,  clr_resp_nxt;   // clear came from an item, answer it
  logic [POS_W-1:0]  size_r,      size_nxt;
  logic              out_valid_r, out_valid_nxt;

  // walk datapath
  logic [PTR_W-1:0]  p_r,          p_nxt;
  logic              phase_r,      phase_nxt;     // 0 right prefix, 1 left prefix
  logic              pend_r,       pend_nxt;      // a read is in flight
  logic              pend_sub_r,   pend_sub_nxt;  // in-flight read belongs to left prefix
  logic [DATA_W-1:0] acc_r,        acc_nxt;
  logic [DATA_W-1:0] delta_r,      delta_nxt;
  logic [POS_W-1:0]  first_r,      first_nxt;
  logic [DATA_W-1:0] out_total_r,  out_total_nxt;
  logic              out_status_r, out_status_nxt;

  logic              accept;
  logic              first_bad;
  logic              second_bad;
  logic [PTR_W-1:0]  low_bit;
  logic [ADDR_W-1:0] cell_addr;
  logic              clr_last;

  assign busy            = (state_r != ST_IDLE);
  assign accept          = start && !busy;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_range_total = $signed(out_total_r);
  assign out_status      = out_status_r;

  assign first_bad  = (in_first_position == '0) || (in_first_position > size_r);
  assign second_bad = (in_second_position == '0) || (in_second_position > size_r);
  assign low_bit    = p_r & (~p_r + PTR_W'(1));
  assign cell_addr  = ADDR_W'(p_r - PTR_W'(1));
  assign clr_last   = (clr_idx_r == ADDR_W'(MAX_POSITIONS - 1));

  // size register: zero reads as one, anything above the store as its depth
  always_comb begin
    size_nxt = size_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_size_in_use == '0) begin
        size_nxt = POS_W'(1);
      end else if (32'(cfg_size_in_use) > 32'(MAX_POSITIONS)) begin
        size_nxt = POS_W'(MAX_POSITIONS);
      end else begin
        size_nxt = cfg_size_in_use;
      end
    end
  end

  // sequencer: next state, walk pointer, memory strobes and result
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    clr_resp_nxt   = clr_resp_r;
    out_valid_nxt  = 1'b0;
    p_nxt          = p_r;
    phase_nxt      = phase_r;
    pend_nxt       = pend_r;
    pend_sub_nxt   = pend_sub_r;
    acc_nxt        = acc_r;
    delta_nxt      = delta_r;
    first_nxt      = first_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    mem_re         = 1'b0;
    mem_raddr      = cell_addr;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr;
    mem_wdata      = rdata_r + delta_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_opcode))
            OP_ADD: begin
              if (first_bad) begin
                out_valid_nxt  = 1'b1;
                out_total_nxt  = '0;
                out_status_nxt = 1'b1;
              end else begin
                p_nxt     = {1'b0, in_first_position};
                delta_nxt = DATA_W'(in_delta);
                state_nxt = ST_ADD_RD;
              end
            end
            OP_QUERY: begin
              if (first_bad || second_bad) begin
                out_valid_nxt  = 1'b1;
                out_total_nxt  = '0;
                out_status_nxt = 1'b1;
              end else begin
                p_nxt     = {1'b0, in_second_position};
                first_nxt = in_first_position;
                phase_nxt = 1'b0;
                pend_nxt  = 1'b0;
                acc_nxt   = '0;
                state_nxt = ST_QUERY;
              end
            end
            OP_CLEAR: begin
              clr_idx_nxt  = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            OP_NONE: begin
              out_valid_nxt  = 1'b1;
              out_total_nxt  = '0;
              out_status_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_total_nxt  = '0;
              out_status_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_ADD_RD: begin
        if (p_r > {1'b0, size_r}) begin
          out_valid_nxt  = 1'b1;
          out_total_nxt  = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_ADD_WR;
        end
      end

      ST_ADD_WR: begin
        mem_we    = 1'b1;
        p_nxt     = p_r + low_bit;
        state_nxt = ST_ADD_RD;
      end

      ST_QUERY: begin
        // fold in the cell read last cycle
        if (pend_r) begin
          acc_nxt = pend_sub_r ? (acc_r - rdata_r) : (acc_r + rdata_r);
        end
        if (p_r != '0) begin
          mem_re       = 1'b1;
          p_nxt        = p_r - low_bit;
          pend_nxt     = 1'b1;
          pend_sub_nxt = phase_r;
        end else if (!phase_r) begin
          p_nxt     = PTR_W'({1'b0, first_r} - PTR_W'(1));
          phase_nxt = 1'b1;
          pend_nxt  = 1'b0;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            out_valid_nxt  = 1'b1;
            out_total_nxt  = acc_r;
            out_status_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end

      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + ADDR_W'(1);
        if (clr_last) begin
          out_valid_nxt  = clr_resp_r;
          out_total_nxt  = '0;
          out_status_nxt = 1'b0;
          clr_resp_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      clr_resp_r  <= 1'b0;
      size_r      <= POS_W'(SIZE_RST);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_resp_r  <= clr_resp_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    phase_r      <= phase_nxt;
    pend_sub_r   <= pend_sub_nxt;
    acc_r        <= acc_nxt;
    delta_r      <= delta_nxt;
    first_r      <= first_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule

// ----- sv/frst_checker.sv -----
// port-level checks for the fenwick range sum table and their bind
module frst_checker
  import frst_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [OP_W-1:0]          in_opcode,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_range_total,
  input logic                     out_status
);

  // results appear only once the block is back to taking items
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an ignored item carries a zero total
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_range_total == '0)
    else $error("error result with nonzero total");

  // unknown opcode is answered at once with an error
  a_none_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_opcode == OP_NONE) |=> out_valid && out_status)
    else $error("unknown opcode not answered with error");

  // a clear sweeps the store before answering
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_opcode == OP_CLEAR) |=> busy && !out_valid)
    else $error("clear did not start its sweep");

endmodule

bind fenwick_range_sum_table frst_checker u_frst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_range_total (out_range_total),
  .out_status      (out_status)
);
